// ----- src/mia_pkg.sv -----
// Shared constants and types for the modular inverse unit.
`default_nettype none
package mia_pkg;

  localparam int WORD_BITS_DEF = 31;
  localparam int ADDR_W        = 3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO     = 2'd1;
  localparam logic [1:0] STATUS_NOT_UNIT = 2'd2;
  localparam logic [1:0] STATUS_RANGE    = 2'd3;

  localparam logic [ADDR_W-1:0] REG_MODULUS = '0;

  typedef struct packed {
    logic done;
    logic not_unit;
  } mia_ctl_t;

endpackage
`default_nettype wire

// ----- src/mia_euclid.sv -----
// Sequencer and shared shift/subtract datapath for the extended Euclidean recurrence.
`default_nettype none
module mia_euclid import mia_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [WORD_BITS-1:0] modulus_i,
  input  wire logic [WORD_BITS-1:0] value_i,
  output logic                      busy_o,
  output mia_ctl_t                  ctl_o,
  output logic      [WORD_BITS-1:0] inverse_o
);

  localparam int KW = $clog2(WORD_BITS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ALIGN = 3'd1;
  localparam logic [2:0] ST_SUB   = 3'd2;
  localparam logic [2:0] ST_FIX   = 3'd3;
  localparam logic [2:0] ST_NEG   = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [WORD_BITS-1:0] r0_q, r0_d, r1_q, r1_d, d_q, d_d;
  logic [WORD_BITS-1:0] u0_q, u0_d, u1_q, u1_d, du_q, du_d;
  logic [KW-1:0]        k_q, k_d;
  logic                 neg0_q, neg0_d, neg1_q, neg1_d;
  logic                 done_q, done_d, not_unit_q, not_unit_d;
  logic [WORD_BITS-1:0] inv_q, inv_d;

  logic [WORD_BITS:0]   d_shl;
  logic                 ge;
  logic [WORD_BITS-1:0] r0_sub, u0_add;

  assign d_shl  = {d_q, 1'b0};
  assign ge     = d_q <= r0_q;
  assign r0_sub = ge ? r0_q - d_q : r0_q;
  assign u0_add = ge ? u0_q + du_q : u0_q;

  always_comb begin
    state_d    = state_q;
    r0_d       = r0_q;
    r1_d       = r1_q;
    d_d        = d_q;
    u0_d       = u0_q;
    u1_d       = u1_q;
    du_d       = du_q;
    k_d        = k_q;
    neg0_d     = neg0_q;
    neg1_d     = neg1_q;
    done_d     = 1'b0;
    not_unit_d = not_unit_q;
    inv_d      = inv_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          r0_d    = modulus_i;
          r1_d    = value_i;
          d_d     = value_i;
          u0_d    = '0;
          u1_d    = WORD_BITS'(1);
          du_d    = WORD_BITS'(1);
          k_d     = '0;
          neg0_d  = 1'b0;
          neg1_d  = 1'b0;
          state_d = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (d_shl <= {1'b0, r0_q}) begin
          d_d  = d_shl[WORD_BITS-1:0];
          du_d = {du_q[WORD_BITS-2:0], 1'b0};
          k_d  = k_q + KW'(1);
        end else begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: begin
        if (k_q == '0) begin
          r0_d    = r1_q;
          r1_d    = r0_sub;
          u0_d    = u1_q;
          u1_d    = u0_add;
          d_d     = r0_sub;
          du_d    = u0_add;
          neg0_d  = neg1_q;
          neg1_d  = ~neg1_q;
          state_d = (r0_sub == '0) ? ST_FIX : ST_ALIGN;
        end else begin
          r0_d = r0_sub;
          u0_d = u0_add;
          d_d  = d_q >> 1;
          du_d = du_q >> 1;
          k_d  = k_q - KW'(1);
        end
      end
      ST_FIX: begin
        if (r0_q != WORD_BITS'(1)) begin
          done_d     = 1'b1;
          not_unit_d = 1'b1;
          inv_d      = '0;
          state_d    = ST_IDLE;
        end else begin
          if (u0_q >= modulus_i) begin
            u0_d = u0_q - modulus_i;
          end
          state_d = ST_NEG;
        end
      end
      ST_NEG: begin
        done_d     = 1'b1;
        not_unit_d = 1'b0;
        inv_d      = (neg0_q && u0_q != '0) ? modulus_i - u0_q : u0_q;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      done_q     <= 1'b0;
      k_q        <= '0;
      not_unit_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      done_q     <= done_d;
      k_q        <= k_d;
      not_unit_q <= not_unit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q   <= r0_d;
    r1_q   <= r1_d;
    d_q    <= d_d;
    u0_q   <= u0_d;
    u1_q   <= u1_d;
    du_q   <= du_d;
    neg0_q <= neg0_d;
    neg1_q <= neg1_d;
    inv_q  <= inv_d;
  end

  assign busy_o         = (state_q != ST_IDLE) || done_q;
  assign ctl_o.done     = done_q;
  assign ctl_o.not_unit = not_unit_q;
  assign inverse_o      = inv_q;

endmodule
`default_nettype wire

// ----- src/modular_inverse_unit.sv -----
// Top level of the modular inverse unit: register port, input checks and result register.
//
// Usage: write the modulus through the APB-style port (byte address 0), then
// send values on the input channel (in_valid_i / in_stall_o, field value_i).
// Each value yields one transfer on the output channel (out_valid_o /
// out_stall_i) carrying inverse_o and status_o.
// Out-of-range, zero and self-inverse values (1 and modulus-1) are resolved
// at the input and appear in the cycle after the transfer.
// All other values run the extended Euclidean recurrence on one shared
// shift/subtract unit: for each quotient the divisor is shifted up one bit
// at a time to align it, then subtracted and shifted back down one bit at
// a time, so latency is data dependent.
// One value is in flight at a time; in_stall_o stays high while the
// recurrence runs and while an unread result is being stalled.
// Reset clears both channels and sets the modulus to 2.
// A stalled result holds its value until the receiver takes it.
`default_nettype none
module modular_inverse_unit import mia_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int DATA_W    = (WORD_BITS > 32) ? 64 : 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_W-1:0]    paddr,
  input  wire logic [DATA_W-1:0]    pwdata,
  output logic      [DATA_W-1:0]    prdata,
  output logic                      pready,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [WORD_BITS-1:0] value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [WORD_BITS-1:0] inverse_o,
  output logic      [1:0]           status_o
);

  logic [WORD_BITS-1:0] modulus_q;
  logic                 out_valid_q;
  logic [WORD_BITS-1:0] inverse_q;
  logic [1:0]           status_q;

  logic                 accept, drain, cfg_wr;
  logic                 is_range, is_zero, is_self, start;
  logic                 core_busy;
  mia_ctl_t             core_ctl;
  logic [WORD_BITS-1:0] core_inv;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MODULUS) ? DATA_W'(modulus_q) : '0;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_MODULUS);

  assign drain      = out_valid_q && !out_stall_i;
  assign in_stall_o = core_busy || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign is_range = value_i >= modulus_q;
  assign is_zero  = value_i == '0;
  assign is_self  = (value_i == WORD_BITS'(1)) || (value_i == modulus_q - WORD_BITS'(1));
  assign start    = accept && !is_range && !is_zero && !is_self;

  mia_euclid #(
    .WORD_BITS(WORD_BITS)
  ) u_euclid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .modulus_i(modulus_q),
    .value_i  (value_i),
    .busy_o   (core_busy),
    .ctl_o    (core_ctl),
    .inverse_o(core_inv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= WORD_BITS'(2);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        modulus_q <= pwdata[WORD_BITS-1:0];
      end
      if ((accept && !start) || core_ctl.done) begin
        out_valid_q <= 1'b1;
      end else if (drain) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_ctl.done) begin
      inverse_q <= core_inv;
      status_q  <= core_ctl.not_unit ? STATUS_NOT_UNIT : STATUS_OK;
    end else if (accept && !start) begin
      if (is_range) begin
        inverse_q <= '0;
        status_q  <= STATUS_RANGE;
      end else if (is_zero) begin
        inverse_q <= '0;
        status_q  <= STATUS_ZERO;
      end else begin
        inverse_q <= value_i;
        status_q  <= STATUS_OK;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign inverse_o   = inverse_q;
  assign status_o    = status_q;

endmodule
`default_nettype wire

// ----- src/mia_checker.sv -----
// Port-level checks for the modular inverse unit, bound to the top level.
`default_nettype none
module mia_checker import mia_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic [WORD_BITS-1:0] value_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [WORD_BITS-1:0] inverse_o,
  input wire logic [1:0]           status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(inverse_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |-> inverse_o == '0)
    else $error("nonzero inverse with failing status");

  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_OK |-> inverse_o != '0)
    else $error("zero inverse with ok status");

  a_one_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && value_i == WORD_BITS'(1) |=>
      out_valid_o && ((status_o == STATUS_OK && inverse_o == WORD_BITS'(1)) ||
                      status_o == STATUS_RANGE))
    else $error("value one not returned as its own inverse");

endmodule

bind modular_inverse_unit mia_checker #(
  .WORD_BITS(WORD_BITS)
) u_mia_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .value_i    (value_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .inverse_o  (inverse_o),
  .status_o   (status_o)
);
`default_nettype wire
